[design/ami_pkg.sv]
// Package for the affine 3x4 matrix inverse: word types, widths and constants.
// Used by ami_div and affine_matrix_inverse; depends on nothing.
`timescale 1ns / 1ps

package ami_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 12;
    localparam int WORD_W        = 32;
    // Quotient bits developed per lane; anything at or above 2^QB saturates.
    localparam int QB            = 33;
    // Magnitude width of the determinant and of the translation numerators.
    localparam int DW            = 96;

    localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0] a11;
        logic signed [WORD_W-1:0] a12;
        logic signed [WORD_W-1:0] a13;
        logic signed [WORD_W-1:0] tx;
        logic signed [WORD_W-1:0] a21;
        logic signed [WORD_W-1:0] a22;
        logic signed [WORD_W-1:0] a23;
        logic signed [WORD_W-1:0] ty;
        logic signed [WORD_W-1:0] a31;
        logic signed [WORD_W-1:0] a32;
        logic signed [WORD_W-1:0] a33;
        logic signed [WORD_W-1:0] tz;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] b11;
        logic signed [WORD_W-1:0] b12;
        logic signed [WORD_W-1:0] b13;
        logic signed [WORD_W-1:0] ux;
        logic signed [WORD_W-1:0] b21;
        logic signed [WORD_W-1:0] b22;
        logic signed [WORD_W-1:0] b23;
        logic signed [WORD_W-1:0] uy;
        logic signed [WORD_W-1:0] b31;
        logic signed [WORD_W-1:0] b32;
        logic signed [WORD_W-1:0] b33;
        logic signed [WORD_W-1:0] uz;
    } t_out;

    // Control that enters the divider beside the operands.
    typedef struct packed {
        logic             vld;
        logic [LANES-1:0] neg;
    } t_div_ctl;

endpackage

[design/ami_div.sv]
// Pipelined restoring divider, twelve lanes sharing one divisor, one quotient
// bit per stage, with rounding and 32-bit saturation. Depends on ami_pkg.
`timescale 1ns / 1ps

module ami_div #(
    parameter int NW = ami_pkg::DW + ami_pkg::FRAC_BITS_DEF,
    parameter int DW = ami_pkg::DW,
    parameter int SW = 1
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_ce,
    input  ami_pkg::t_div_ctl                                   i_ctl,
    input  logic [DW-1:0]                                       i_d,
    input  logic [ami_pkg::LANES-1:0][NW-1:0]                   i_num,
    input  logic [SW-1:0]                                       i_side,
    output logic                                                o_vld,
    output logic [ami_pkg::LANES-1:0][ami_pkg::WORD_W-1:0]      o_res,
    output logic [SW-1:0]                                       o_side
);

    localparam int QB = ami_pkg::QB;
    localparam int L  = ami_pkg::LANES;
    localparam int WW = ami_pkg::WORD_W;

    logic                  r_vld  [0:QB];
    logic [DW-1:0]         r_d    [0:QB];
    logic [SW-1:0]         r_side [0:QB];
    logic [L-1:0]          r_neg  [0:QB];
    logic [L-1:0]          r_sat  [0:QB];
    logic [DW-1:0]         r_rem  [0:QB][0:L-1];
    logic [QB-1:0]         r_low  [0:QB][0:L-1];
    logic [QB-1:0]         r_q    [0:QB][0:L-1];

    logic [L-1:0]          n_sat0;
    logic [DW-1:0]         n_rem0 [0:L-1];
    logic [DW-1:0]         n_rem  [1:QB][0:L-1];
    logic [QB-1:0]         n_low  [1:QB][0:L-1];
    logic [QB-1:0]         n_q    [1:QB][0:L-1];

    logic                  r_ovld;
    logic [L-1:0][WW-1:0]  r_res;
    logic [SW-1:0]         r_oside;
    logic [L-1:0][WW-1:0]  n_res;

    // Entry: a numerator at or above D * 2^QB saturates outright; otherwise its
    // upper part is already below D and seeds the remainder.
    always_comb begin
        for (int l = 0; l < L; l++) begin
            n_sat0[l] = ((DW+QB)'(i_num[l]) >= {i_d, {QB{1'b0}}});
            n_rem0[l] = DW'(i_num[l][NW-1:QB]);
        end
    end

    always_comb begin
        logic [DW:0] t;
        logic        ge;
        for (int s = 1; s <= QB; s++) begin
            for (int l = 0; l < L; l++) begin
                t  = {r_rem[s-1][l], r_low[s-1][l][QB-1]};
                ge = (t >= {1'b0, r_d[s-1]});
                n_rem[s][l] = ge ? DW'(t - {1'b0, r_d[s-1]}) : t[DW-1:0];
                n_low[s][l] = {r_low[s-1][l][QB-2:0], 1'b0};
                n_q[s][l]   = {r_q[s-1][l][QB-2:0], ge};
            end
        end
    end

    always_comb begin
        logic          rnd;
        logic [QB:0]   qr;
        for (int l = 0; l < L; l++) begin
            rnd = ({r_rem[QB][l], 1'b0} >= {1'b0, r_d[QB]});
            qr  = {1'b0, r_q[QB][l]} + (QB+1)'(rnd);
            if (r_sat[QB][l]) begin
                n_res[l] = r_neg[QB][l] ? ami_pkg::SAT_MIN : ami_pkg::SAT_MAX;
            end else if (!r_neg[QB][l]) begin
                n_res[l] = (qr > (QB+1)'(ami_pkg::SAT_MAX)) ? ami_pkg::SAT_MAX : qr[WW-1:0];
            end else begin
                n_res[l] = (qr > (QB+1)'(ami_pkg::SAT_MIN)) ? ami_pkg::SAT_MIN
                                                            : WW'(-qr[WW-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) r_vld[s] <= 1'b0;
            r_ovld <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_ctl.vld;
            for (int s = 1; s <= QB; s++) r_vld[s] <= r_vld[s-1];
            r_ovld <= r_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d[0]    <= i_d;
            r_side[0] <= i_side;
            r_neg[0]  <= i_ctl.neg;
            r_sat[0]  <= n_sat0;
            for (int l = 0; l < L; l++) begin
                r_rem[0][l] <= n_rem0[l];
                r_low[0][l] <= i_num[l][QB-1:0];
                r_q[0][l]   <= '0;
            end
            for (int s = 1; s <= QB; s++) begin
                r_d[s]    <= r_d[s-1];
                r_side[s] <= r_side[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_sat[s]  <= r_sat[s-1];
                for (int l = 0; l < L; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_low[s][l] <= n_low[s][l];
                    r_q[s][l]   <= n_q[s][l];
                end
            end
            r_res   <= n_res;
            r_oside <= r_side[QB];
        end
    end

    assign o_vld  = r_ovld;
    assign o_res  = r_res;
    assign o_side = r_oside;

    // A zero divisor must mark every lane as saturated at entry.
    a_zero_div_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && r_d[0] == '0) |-> (r_sat[0] == {L{1'b1}}))
        else $error("zero divisor entered without saturation");

    // The seeded remainder of lane 0, if it did not saturate, is below the divisor.
    a_seed_below_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !r_sat[0][0]) |-> (r_rem[0][0] < r_d[0]))
        else $error("seed remainder not below divisor");

    // After the last quotient step lane L-1's remainder is still below the divisor.
    a_final_below_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[QB] && !r_sat[QB][L-1]) |-> (r_rem[QB][L-1] < r_d[QB]))
        else $error("final remainder not below divisor");

endmodule

[design/affine_matrix_inverse.sv]
// Top level of the affine 3x4 matrix inverse: cofactors, determinant and
// translation numerators in a multiply pipeline, then ami_div. Uses ami_pkg.
//
//   channel   valid     ready     word
//   input     i_valid   o_ready   i_data  (ami_pkg::t_in)
//   output    o_valid   i_ready   o_data  (ami_pkg::t_out)
//
// One word is taken per cycle while the pipeline is not held; a result passes
// through 43 register stages (7 multiply/add stages, 35 divider stages, output register).
// The depth is set by the divider, which develops one quotient bit per stage.
// All stages advance together; when the output register is full and not
// taken, the whole pipeline holds and o_ready is low.
// Reset clears the valid bits only.
`timescale 1ns / 1ps

module affine_matrix_inverse #(
    parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ami_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ami_pkg::t_out o_data
);

    localparam int L  = ami_pkg::LANES;
    localparam int WW = ami_pkg::WORD_W;
    localparam int DW = ami_pkg::DW;
    localparam int NW = DW + FRAC_BITS;
    localparam int SW = 1 + $bits(ami_pkg::t_in);

    logic ce;

    logic               r_v  [1:7];
    ami_pkg::t_in       r_x  [1:7];
    logic signed [63:0] r_p  [0:17];
    logic signed [64:0] r_n  [3:6][0:8];
    logic signed [64:0] r_pl [0:11];
    logic signed [64:0] r_ph [0:11];
    logic signed [96:0] r_pr [0:11];
    logic signed [96:0] r_det;
    logic signed [96:0] r_num [0:2];

    logic [DW-1:0]             r_dmag;
    logic [L-1:0][NW-1:0]      r_nm;
    logic [L-1:0]              r_neg;
    logic                      r_sing;

    logic signed [63:0] n_p  [0:17];
    logic signed [64:0] n_pl [0:11];
    logic signed [64:0] n_ph [0:11];
    logic signed [31:0] n_op [0:11];
    logic [L-1:0][NW-1:0] n_nm;
    logic [L-1:0]         n_neg;
    logic [DW-1:0]        n_dmag;

    ami_pkg::t_div_ctl    div_ctl;
    logic                 div_vld;
    logic [L-1:0][WW-1:0] div_res;
    logic [SW-1:0]        div_side;
    logic [L-1:0][WW-1:0] res_arr;

    logic          r_ovld;
    ami_pkg::t_out r_out;

    assign ce      = !r_ovld || i_ready;
    assign o_ready = ce;

    // Cofactor products; each pair below forms one adjugate entry.
    always_comb begin
        ami_pkg::t_in x;
        x = r_x[1];
        n_p[0]  = x.a22 * x.a33;  n_p[1]  = x.a23 * x.a32;
        n_p[2]  = x.a13 * x.a32;  n_p[3]  = x.a12 * x.a33;
        n_p[4]  = x.a12 * x.a23;  n_p[5]  = x.a13 * x.a22;
        n_p[6]  = x.a23 * x.a31;  n_p[7]  = x.a21 * x.a33;
        n_p[8]  = x.a11 * x.a33;  n_p[9]  = x.a13 * x.a31;
        n_p[10] = x.a13 * x.a21;  n_p[11] = x.a11 * x.a23;
        n_p[12] = x.a21 * x.a32;  n_p[13] = x.a22 * x.a31;
        n_p[14] = x.a12 * x.a31;  n_p[15] = x.a11 * x.a32;
        n_p[16] = x.a11 * x.a22;  n_p[17] = x.a12 * x.a21;
    end

    // Second operand of each wide product: translation for the numerators,
    // first row for the determinant.
    always_comb begin
        ami_pkg::t_in x;
        x = r_x[3];
        for (int i = 0; i < 3; i++) begin
            n_op[i*3]   = x.tx;
            n_op[i*3+1] = x.ty;
            n_op[i*3+2] = x.tz;
        end
        n_op[9]  = x.a11;
        n_op[10] = x.a12;
        n_op[11] = x.a13;
    end

    // Cofactors are 65 bits; each is split so that no multiplier exceeds 33x32.
    always_comb begin
        logic signed [64:0] na;
        for (int m = 0; m < 12; m++) begin
            na = (m < 9) ? r_n[3][m] : r_n[3][(m-9)*3];
            n_pl[m] = $signed({1'b0, na[31:0]}) * n_op[m];
            n_ph[m] = $signed(na[64:32]) * n_op[m];
        end
    end

    always_comb begin
        logic [64:0] cm;
        logic [96:0] um;
        logic [96:0] dm;
        dm     = r_det[96] ? 97'(-r_det) : 97'(r_det);
        n_dmag = dm[DW-1:0];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cm = r_n[6][i*3+j][64] ? 65'(-r_n[6][i*3+j]) : 65'(r_n[6][i*3+j]);
                n_nm[i*4+j]  = NW'(cm[63:0]) << (2*FRAC_BITS);
                n_neg[i*4+j] = r_n[6][i*3+j][64] ^ r_det[96];
            end
            // The translation is the negated product, hence the inverted sign.
            um = r_num[i][96] ? 97'(-r_num[i]) : 97'(r_num[i]);
            n_nm[i*4+3]  = NW'(um[DW-1:0]) << FRAC_BITS;
            n_neg[i*4+3] = !r_num[i][96] ^ r_det[96];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 7; s++) r_v[s] <= 1'b0;
        end else if (ce) begin
            r_v[1] <= i_valid;
            for (int s = 2; s <= 7; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x[1] <= i_data;
            for (int s = 2; s <= 7; s++) r_x[s] <= r_x[s-1];
            for (int k = 0; k < 18; k++) r_p[k] <= n_p[k];
            for (int k = 0; k < 9; k++) begin
                r_n[3][k] <= 65'(r_p[2*k]) - 65'(r_p[2*k+1]);
                r_n[4][k] <= r_n[3][k];
                r_n[5][k] <= r_n[4][k];
                r_n[6][k] <= r_n[5][k];
            end
            for (int m = 0; m < 12; m++) begin
                r_pl[m] <= n_pl[m];
                r_ph[m] <= n_ph[m];
                r_pr[m] <= (97'(r_ph[m]) <<< 32) + 97'(r_pl[m]);
            end
            r_det <= r_pr[9] + r_pr[10] + r_pr[11];
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= r_pr[i*3] + r_pr[i*3+1] + r_pr[i*3+2];
            end
            r_dmag <= n_dmag;
            r_nm   <= n_nm;
            r_neg  <= n_neg;
            r_sing <= (r_det == '0);
        end
    end

    assign div_ctl.vld = r_v[7];
    assign div_ctl.neg = r_neg;

    ami_div #(
        .NW (NW),
        .DW (DW),
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_ctl   (div_ctl),
        .i_d     (r_dmag),
        .i_num   (r_nm),
        .i_side  ({r_sing, r_x[7]}),
        .o_vld   (div_vld),
        .o_res   (div_res),
        .o_side  (div_side)
    );

    // Lane 0 is the first field of the word, which sits in the top bits.
    always_comb begin
        for (int k = 0; k < L; k++) res_arr[L-1-k] = div_res[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (ce) begin
            r_ovld <= div_vld;
        end
    end

    // A singular matrix leaves the block unchanged.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out <= div_side[SW-1] ? ami_pkg::t_out'(div_side[SW-2:0])
                                    : ami_pkg::t_out'(res_arr);
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

endmodule
